>>> rtl/kmp_pkg.sv
// Package for the first-match string finder: sizes, command codes and the
// step-unit result type. Depends on nothing; every other file but kmp_ram imports it.
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int PATTERN_MAX   = 32;
  localparam int POSITION_BITS = 16;
  localparam int CHAR_W        = 8;
  localparam int MATCH_POS_W   = 16;
  localparam int IDX_W         = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W         = $clog2(PATTERN_MAX + 1);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_TEXT    = 1'b1
  } cmd_e;

  typedef struct packed {
    logic hit;
    logic walk;
    len_t next;
  } step_t;

endpackage

>>> rtl/kmp_in_if.sv
// Input channel of the string finder: valid, ready and one command beat.
// Depends on kmp_pkg.
`timescale 1ns / 1ps

interface kmp_in_if import kmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CHAR_W-1:0] char_value;
  logic              last_of_run;

  modport source (output valid, command, char_value, last_of_run, input ready);
  modport sink   (input valid, command, char_value, last_of_run, output ready);
endinterface

>>> rtl/kmp_out_if.sv
// Result channel of the string finder: valid, ready and one result beat.
// Depends on kmp_pkg.
`timescale 1ns / 1ps

interface kmp_out_if import kmp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [MATCH_POS_W-1:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

>>> rtl/kmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/kmp_step_unit.sv
// Shared compare unit: one step of the border walk for both the table
// builder and the matcher. Depends on kmp_pkg.
`timescale 1ns / 1ps

module kmp_step_unit import kmp_pkg::*; (
  input  len_t              cur_i,
  input  logic [CHAR_W-1:0] stored_i,
  input  logic [CHAR_W-1:0] char_i,
  input  len_t              fail_i,
  output step_t             step_o
);

  always_comb begin
    step_o.hit  = (stored_i == char_i);
    step_o.walk = (cur_i != '0) && !step_o.hit;
    step_o.next = step_o.walk ? fail_i : (cur_i + LEN_W'(step_o.hit));
  end

endmodule

>>> rtl/kmp_first_match_finder.sv
// Top level of the first-match string finder: sequencer, row state and
// result register around the shared step unit and two RAMs.
// Depends on kmp_pkg, kmp_in_if, kmp_out_if, kmp_ram and kmp_step_unit.
//
//   channel | dir | beat fields                          | accepted when
//   in_i    | in  | command, char_value, last_of_run     | valid && ready
//   res_o   | out | found, match_position               | valid && ready
//
// A beat is taken only in the idle state. A first pattern byte, a dropped
// pattern byte, a text byte under an empty pattern and a text byte of an
// already matched row are handled in idle alone. Any other byte enters the
// compare state, which walks W failure-link steps through the compare unit
// and RAM read port; over a row W averages below one per byte. A row end
// adds the emit state, which loads the result register.
// Reset clears control state only; the RAMs need no clearing pass.
// A waiting result stalls the block only when the next row end arrives.
`timescale 1ns / 1ps

module kmp_first_match_finder import kmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmp_in_if.sink    in_i,
  kmp_out_if.source res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  len_t                     pat_len_q, pat_len_d;
  len_t                     border_q, border_d;
  logic                     closed_q, closed_d;
  len_t                     matched_q, matched_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     row_hit_q, row_hit_d;
  len_t                     cur_q, cur_d;
  logic [CHAR_W-1:0]        char_q, char_d;
  logic                     last_q, last_d;
  logic                     cmd_q, cmd_d;
  logic                     out_valid_q, out_valid_d;
  logic                     found_q, found_d;
  logic [MATCH_POS_W-1:0]   mpos_q, mpos_d;

  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [CHAR_W-1:0] st_rdata;
  logic              fl_we;
  logic [IDX_W-1:0]  fl_waddr;
  len_t              fl_wdata;
  len_t              fl_rdata;
  len_t              pidx;
  step_t             step;
  logic              accept;

  kmp_ram #(.WIDTH(CHAR_W), .DEPTH(PATTERN_MAX)) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (in_i.char_value),
    .raddr_i (cur_d[IDX_W-1:0]),
    .rdata_o (st_rdata)
  );

  kmp_ram #(.WIDTH(LEN_W), .DEPTH(PATTERN_MAX)) u_failure_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (IDX_W'(cur_d - LEN_W'(1))),
    .rdata_o (fl_rdata)
  );

  kmp_step_unit u_step (
    .cur_i    (cur_q),
    .stored_i (st_rdata),
    .char_i   (char_q),
    .fail_i   (fl_rdata),
    .step_o   (step)
  );

  assign in_i.ready           = (state_q == ST_IDLE);
  assign accept               = in_i.valid && in_i.ready;
  assign res_o.valid          = out_valid_q;
  assign res_o.found          = found_q;
  assign res_o.match_position = mpos_q;
  assign pidx                 = closed_q ? '0 : pat_len_q;
  assign st_waddr             = pidx[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    pat_len_d   = pat_len_q;
    border_d    = border_q;
    closed_d    = closed_q;
    matched_d   = matched_q;
    pos_d       = pos_q;
    row_hit_d   = row_hit_q;
    cur_d       = cur_q;
    char_d      = char_q;
    last_d      = last_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q && !res_o.ready;
    found_d     = found_q;
    mpos_d      = mpos_q;
    st_we       = 1'b0;
    fl_we       = 1'b0;
    fl_waddr    = pat_len_q[IDX_W-1:0];
    fl_wdata    = step.next;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          char_d = in_i.char_value;
          last_d = in_i.last_of_run;
          cmd_d  = in_i.command;
          if (in_i.command == CMD_PATTERN) begin
            closed_d = in_i.last_of_run;
            if (closed_q) begin
              pat_len_d = '0;
              border_d  = '0;
              matched_d = '0;
              pos_d     = '0;
              row_hit_d = 1'b0;
            end
            if (pidx < LEN_W'(PATTERN_MAX)) begin
              st_we = 1'b1;
              if (pidx == '0) begin
                fl_we     = 1'b1;
                fl_waddr  = '0;
                fl_wdata  = '0;
                border_d  = '0;
                pat_len_d = LEN_W'(1);
              end else begin
                cur_d   = border_q;
                state_d = ST_CMP;
              end
            end
          end else begin
            closed_d = 1'b1;
            if (row_hit_q) begin
              state_d = in_i.last_of_run ? ST_EMIT : ST_IDLE;
            end else if (pat_len_q == '0) begin
              row_hit_d = 1'b1;
              state_d   = in_i.last_of_run ? ST_EMIT : ST_IDLE;
            end else begin
              cur_d   = matched_q;
              state_d = ST_CMP;
            end
          end
        end
      end
      ST_CMP: begin
        if (step.walk) begin
          cur_d = step.next;
        end else if (cmd_q == CMD_PATTERN) begin
          fl_we     = 1'b1;
          border_d  = step.next;
          pat_len_d = pat_len_q + LEN_W'(1);
          state_d   = ST_IDLE;
        end else begin
          if (step.next >= pat_len_q) begin
            row_hit_d = 1'b1;
            matched_d = '0;
            pos_d     = (pos_q == POS_MAX) ? POS_MAX
                        : (pos_q + POSITION_BITS'(1) - POSITION_BITS'(pat_len_q));
          end else begin
            matched_d = step.next;
            pos_d     = (pos_q == POS_MAX) ? POS_MAX : (pos_q + POSITION_BITS'(1));
          end
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          found_d     = row_hit_q;
          mpos_d      = row_hit_q ? MATCH_POS_W'(pos_q) : '0;
          matched_d   = '0;
          pos_d       = '0;
          row_hit_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pat_len_q   <= '0;
      border_q    <= '0;
      closed_q    <= 1'b0;
      matched_q   <= '0;
      pos_q       <= '0;
      row_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pat_len_q   <= pat_len_d;
      border_q    <= border_d;
      closed_q    <= closed_d;
      matched_q   <= matched_d;
      pos_q       <= pos_d;
      row_hit_q   <= row_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    char_q  <= char_d;
    last_q  <= last_d;
    cmd_q   <= cmd_d;
    found_q <= found_d;
    mpos_q  <= mpos_d;
  end

  // The walk index always stays inside the stored pattern.
  a_cur_in_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (cur_q < pat_len_q))
    else $error("walk index beyond stored pattern");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_len_q <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_border_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pat_len_q != '0) |-> (border_q < pat_len_q))
    else $error("border not shorter than pattern");

  a_matched_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (matched_q == '0) || (matched_q < pat_len_q))
    else $error("partial match not shorter than pattern");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || res_o.ready)) |=> out_valid_q)
    else $error("row end did not load a result");

endmodule

>>> tb/tb_kmp_first_match_finder.sv
// Self-checking testbench for kmp_first_match_finder: directed and random pattern/text
// beats, random idling and back-pressure, checked against a predictor.
// Depends on kmp_pkg, kmp_in_if, kmp_out_if and the kmp_first_match_finder RTL.
`timescale 1ns / 1ps

module tb_kmp_first_match_finder;
  import kmp_pkg::*;

  localparam int unsigned SEND_IDLE_A  = 15;
  localparam int unsigned RECV_IDLE_A  = 51;
  localparam int unsigned RANDOM_BEATS = 1800;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned END_SLACK    = 64;
  localparam longint      TIMEOUT_NS   = 20_000_000;

  typedef enum logic [1:0] {
    STIM_BEAT,
    STIM_PACE,
    STIM_HOLD,
    STIM_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e        kind;
    cmd_e              command;
    logic [CHAR_W-1:0] char_value;
    logic              last_of_run;
    int unsigned       send_pct;
    int unsigned       recv_pct;
  } stim_t;

  typedef struct packed {
    logic                   found;
    logic [MATCH_POS_W-1:0] position;
  } row_result_t;

  logic clk_i;
  logic rst_ni;

  kmp_in_if  in_if ();
  kmp_out_if res_if ();

  kmp_first_match_finder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  stim_t             stim_q [$];
  row_result_t       expected_rows [$];
  int unsigned       beats_queued;
  int unsigned       rows_predicted;
  int unsigned       rows_checked;
  int unsigned       error_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       hold_requests;
  int unsigned       holds_served;
  int unsigned       hold_left;
  logic [CHAR_W-1:0] alphabet [3];

  logic [CHAR_W-1:0]        pat_store [PATTERN_MAX];
  len_t                     fail_link [PATTERN_MAX];
  len_t                     pat_len;
  len_t                     border_len;
  logic                     pat_closed;
  len_t                     match_len;
  logic [POSITION_BITS-1:0] row_pos;
  logic                     row_hit;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("kmp_first_match_finder: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb error at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void push_beat(cmd_e cmd, logic [CHAR_W-1:0] c, logic last);
    stim_t s;
    s.kind        = STIM_BEAT;
    s.command     = cmd;
    s.char_value  = c;
    s.last_of_run = last;
    s.send_pct    = 0;
    s.recv_pct    = 0;
    stim_q = {stim_q, s};
    beats_queued++;
  endfunction

  function automatic void push_ctrl(stim_kind_e kind, int unsigned send_pct,
                                    int unsigned recv_pct);
    stim_t s;
    s.kind        = kind;
    s.command     = CMD_PATTERN;
    s.char_value  = '0;
    s.last_of_run = 1'b0;
    s.send_pct    = send_pct;
    s.recv_pct    = recv_pct;
    stim_q = {stim_q, s};
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    return alphabet[2'($urandom_range(2))];
  endfunction

  function automatic void clear_row_state();
    match_len = '0;
    row_pos   = '0;
    row_hit   = 1'b0;
  endfunction

  function automatic void predict_search_step(cmd_e cmd, logic [CHAR_W-1:0] c, logic last);
    len_t        b;
    len_t        m;
    len_t        i;
    row_result_t r;
    if (cmd == CMD_PATTERN) begin
      if (pat_closed) begin
        pat_len    = '0;
        border_len = '0;
        pat_closed = 1'b0;
        clear_row_state();
      end
      if (pat_len < LEN_W'(PATTERN_MAX)) begin
        i = pat_len;
        b = border_len;
        pat_store[i[IDX_W-1:0]] = c;
        if (i == '0) begin
          b = '0;
        end else begin
          while (b != '0 && pat_store[b[IDX_W-1:0]] != c)
            b = fail_link[IDX_W'(b - LEN_W'(1))];
          if (pat_store[b[IDX_W-1:0]] == c) b = b + LEN_W'(1);
        end
        fail_link[i[IDX_W-1:0]] = b;
        border_len = b;
        pat_len    = i + LEN_W'(1);
      end
      if (last) pat_closed = 1'b1;
    end else begin
      pat_closed = 1'b1;
      if (!row_hit) begin
        if (pat_len == '0) begin
          row_hit = 1'b1;
        end else begin
          m = match_len;
          while (m != '0 && pat_store[m[IDX_W-1:0]] != c)
            m = fail_link[IDX_W'(m - LEN_W'(1))];
          if (pat_store[m[IDX_W-1:0]] == c) m = m + LEN_W'(1);
          if (m >= pat_len) begin
            row_hit   = 1'b1;
            match_len = '0;
            if (row_pos != POS_MAX)
              row_pos = row_pos + POSITION_BITS'(1) - POSITION_BITS'(pat_len);
          end else begin
            match_len = m;
            if (row_pos != POS_MAX) row_pos = row_pos + POSITION_BITS'(1);
          end
        end
      end
      if (last) begin
        r.found    = row_hit;
        r.position = row_hit ? MATCH_POS_W'(row_pos) : '0;
        expected_rows = {expected_rows, r};
        rows_predicted++;
        clear_row_state();
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : driver
    stim_t head;
    logic  offer;
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.command     <= CMD_PATTERN;
      in_if.char_value  <= '0;
      in_if.last_of_run <= 1'b0;
      recv_idle_pct     <= 0;
      hold_requests     <= 0;
      send_idle_pct      = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_search_step(cmd_e'(in_if.command), in_if.char_value, in_if.last_of_run);
      end
      if (!in_if.valid || in_if.ready) begin
        offer = 1'b0;
        if (stim_q.size() != 0) begin
          head = stim_q[0];
          case (head.kind)
            STIM_BEAT: begin
              if ($urandom_range(99) >= send_idle_pct) begin
                offer = 1'b1;
                void'(stim_q.pop_front());
                in_if.command     <= head.command;
                in_if.char_value  <= head.char_value;
                in_if.last_of_run <= head.last_of_run;
              end
            end
            STIM_PACE: begin
              send_idle_pct  = head.send_pct;
              recv_idle_pct <= head.recv_pct;
              void'(stim_q.pop_front());
            end
            STIM_HOLD: begin
              hold_requests <= hold_requests + 1;
              void'(stim_q.pop_front());
            end
            default: begin
              if (rows_checked == rows_predicted) void'(stim_q.pop_front());
            end
          endcase
        end
        in_if.valid <= offer;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    row_result_t want;
    if (!rst_ni) begin
      rows_checked <= 0;
    end else if (res_if.valid && res_if.ready) begin
      rows_checked <= rows_checked + 1;
      if (expected_rows.size() == 0) begin
        report_mismatch("result beat with no row pending", res_if.match_position, 0);
      end else begin
        want = expected_rows.pop_front();
        if (res_if.found !== want.found)
          report_mismatch("found", res_if.found, want.found);
        if (res_if.match_position !== want.position)
          report_mismatch("match_position", res_if.match_position, want.position);
      end
    end
  end

  initial begin : stimulus
    int unsigned       plen;
    int unsigned       nrows;
    int unsigned       rlen;
    int unsigned       ins_at;
    int unsigned       random_start;
    int unsigned       sel;
    logic [CHAR_W-1:0] pat_bytes [48];
    logic [CHAR_W-1:0] c;
    logic              cut;
    bit                phase_a_drained;
    bit                phase_b_set;
    bit                phase_c_set;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_PATTERN;
    in_if.char_value  = '0;
    in_if.last_of_run = 1'b0;
    res_if.ready      = 1'b0;
    beats_queued      = 0;
    rows_predicted    = 0;
    error_count       = 0;
    phase_a_drained   = 1'b0;
    phase_b_set       = 1'b0;
    phase_c_set       = 1'b0;
    pat_len           = '0;
    border_len        = '0;
    pat_closed        = 1'b0;
    clear_row_state();

    push_ctrl(STIM_PACE, SEND_IDLE_A, RECV_IDLE_A);

    // Rows searched before any pattern byte see an empty pattern.
    push_beat(CMD_TEXT, 8'h00, 1'b1);
    push_beat(CMD_TEXT, 8'hFF, 1'b0);
    push_beat(CMD_TEXT, 8'h10, 1'b1);
    push_beat(CMD_PATTERN, 8'h00, 1'b0);
    push_beat(CMD_PATTERN, 8'hFF, 1'b1);
    push_beat(CMD_TEXT, 8'hFF, 1'b0);
    push_beat(CMD_TEXT, 8'h00, 1'b0);
    push_beat(CMD_TEXT, 8'h00, 1'b0);
    push_beat(CMD_TEXT, 8'hFF, 1'b0);
    push_beat(CMD_TEXT, 8'h00, 1'b1);
    push_beat(CMD_TEXT, 8'h12, 1'b1);
    push_beat(CMD_PATTERN, 8'h61, 1'b0);
    push_beat(CMD_PATTERN, 8'h62, 1'b0);
    push_beat(CMD_PATTERN, 8'h61, 1'b1);
    push_beat(CMD_TEXT, 8'h61, 1'b0);
    push_beat(CMD_TEXT, 8'h62, 1'b0);
    push_beat(CMD_TEXT, 8'h61, 1'b0);
    push_beat(CMD_TEXT, 8'h62, 1'b0);
    push_beat(CMD_TEXT, 8'h61, 1'b1);
    // An open pattern is closed by the first text beat.
    push_beat(CMD_PATTERN, 8'h7A, 1'b0);
    push_beat(CMD_TEXT, 8'h7A, 1'b1);

    push_ctrl(STIM_DRAIN, 0, 0);
    push_ctrl(STIM_HOLD, 0, 0);

    random_start = beats_queued;
    while (beats_queued - random_start < RANDOM_BEATS) begin
      if (!phase_a_drained && beats_queued - random_start >= RANDOM_BEATS / 6) begin
        phase_a_drained = 1'b1;
        push_ctrl(STIM_DRAIN, 0, 0);
      end
      if (!phase_b_set && beats_queued - random_start >= RANDOM_BEATS / 3) begin
        phase_b_set = 1'b1;
        push_ctrl(STIM_PACE, RECV_IDLE_A, SEND_IDLE_A);
        push_ctrl(STIM_HOLD, 0, 0);
      end
      if (!phase_c_set && beats_queued - random_start >= 2 * RANDOM_BEATS / 3) begin
        phase_c_set = 1'b1;
        push_ctrl(STIM_DRAIN, 0, 0);
        push_ctrl(STIM_PACE, 0, 0);
      end

      for (int k = 0; k < 3; k++) alphabet[2'(k)] = CHAR_W'($urandom_range(255));
      sel = $urandom_range(99);
      if (sel < 70) plen = $urandom_range(4, 1);
      else if (sel < 90) plen = $urandom_range(12, 5);
      else plen = $urandom_range(40, 30);
      for (int k = 0; k < plen; k++) begin
        pat_bytes[6'(k)] = ($urandom_range(99) < 90) ? pick_char()
                                                     : CHAR_W'($urandom_range(255));
        push_beat(CMD_PATTERN, pat_bytes[6'(k)],
                  (k == plen - 1) && ($urandom_range(99) < 80));
      end

      nrows = $urandom_range(8, 2);
      for (int row = 0; row < nrows; row++) begin
        rlen   = $urandom_range(24, 1) + ((plen > 12) ? plen : 0);
        ins_at = rlen;
        if (plen <= rlen && $urandom_range(99) < 50) ins_at = $urandom_range(rlen - plen);
        cut = ($urandom_range(99) < 4);
        for (int j = 0; j < rlen; j++) begin
          if (j >= ins_at && j < ins_at + plen) c = pat_bytes[6'(j - ins_at)];
          else if ($urandom_range(99) < 90) c = pick_char();
          else c = CHAR_W'($urandom_range(255));
          push_beat(CMD_TEXT, c, (j == rlen - 1) && !cut);
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() != 0 || in_if.valid || rows_checked != rows_predicted)
      @(negedge clk_i);
    repeat (END_SLACK) @(negedge clk_i);

    if (expected_rows.size() != 0)
      report_mismatch("rows still pending at end", 0, expected_rows.size());
    if (error_count == 0) begin
      $display("kmp_first_match_finder: match");
    end else begin
      $display("kmp_first_match_finder: mismatch");
    end
    $finish;
  end

endmodule
